// File: design/sbsi_pkg.sv
// Shared types, constants and helpers for the sorted block set intersection.
// Used by the lane comparator, the result merge stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sbsi_pkg;

  localparam int ELEM_W        = 32;
  localparam int IN_ELEMS      = 16;
  localparam int CNT_IN_W      = 5;
  localparam int LANES_DEFAULT = 16;
  localparam int IN_DATA_W     = 520;
  localparam int OUT_DATA_W    = 40;
  localparam int WANT_W        = 2;

  typedef enum logic [WANT_W-1:0] {
    WANT_A    = 2'd0,
    WANT_B    = 2'd1,
    WANT_BOTH = 2'd2
  } want_t;

  typedef struct packed {
    want_t want;
    logic  fin;
  } step_ctl_t;

  function automatic want_t need_code(input logic ha, input logic hb, input logic dn);
    want_t w;
    if (dn) begin
      w = WANT_A;
    end else if (!ha && !hb) begin
      w = WANT_BOTH;
    end else if (ha && !hb) begin
      w = WANT_B;
    end else begin
      w = WANT_A;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/sbsi_lane.sv
// One comparator lane: checks a single A element against every valid B element.
// Depends on sbsi_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_lane #(
  parameter int LANES = sbsi_pkg::LANES_DEFAULT
) (
  input  logic [sbsi_pkg::ELEM_W-1:0] a_elem,
  input  logic                        a_ok,
  input  logic [sbsi_pkg::ELEM_W-1:0] b_elems [LANES],
  input  logic [LANES-1:0]            b_mask,
  output logic                        hit
);
  import sbsi_pkg::*;

  logic [LANES-1:0] eq;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      eq[j] = (a_elem == b_elems[j]) && b_mask[j];
    end
  end

  assign hit = a_ok && (|eq);

endmodule

`default_nettype wire

// File: design/sbsi_merge.sv
// Result stage: holds the hit mask of one step and sends the matches in A lane
// order, one item per cycle while m_tready is high. Depends on sbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_merge #(
  parameter int LANES = sbsi_pkg::LANES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [LANES-1:0]                load_hits,
  input  logic [sbsi_pkg::ELEM_W-1:0]     load_vals [LANES],
  input  sbsi_pkg::step_ctl_t             load_ctl,
  output logic                            can_load,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata fields from bit 0: match_value (32), want_next (2), finished (1), zero fill.
  output logic [sbsi_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: match_valid (1).
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import sbsi_pkg::*;

  logic                 bvalid;
  logic [LANES-1:0]     bhits;
  logic [ELEM_W-1:0]    bvals [LANES];
  step_ctl_t            bctl;
  logic [LANES-1:0]     pick;
  logic [ELEM_W-1:0]    value;
  logic                 last;
  logic                 any;

  always_comb begin
    pick  = bhits & (~bhits + LANES'(1));
    value = '0;
    for (int i = 0; i < LANES; i++) begin
      if (pick[i]) begin
        value = value | bvals[i];
      end
    end
  end

  assign any      = |bhits;
  assign last     = (bhits & (bhits - LANES'(1))) == '0;
  assign can_load = !bvalid || (m_tready && last);

  assign m_tvalid = bvalid;
  assign m_tuser  = bvalid && any;
  assign m_tlast  = bvalid && last;
  assign m_tdata  = {{(OUT_DATA_W - ELEM_W - WANT_W - 1){1'b0}},
                     last ? bctl.fin : 1'b0,
                     last ? bctl.want : WANT_A,
                     any ? value : {ELEM_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
    end else if (load) begin
      bvalid <= 1'b1;
    end else if (bvalid && m_tready) begin
      if (last) begin
        bvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bhits <= load_hits;
      bvals <= load_vals;
      bctl  <= load_ctl;
    end else if (bvalid && m_tready && !last) begin
      bhits <= bhits & ~pick;
    end
  end

  a_nomatch_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty result item not marked last");

  a_more_matches_follow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser))
    else $error("step ended before its last match");

endmodule

`default_nettype wire

// File: design/sorted_block_set_intersection.sv
// Sorted block set intersection: accepts blocks of two sorted lists and emits common elements.
// Top level; uses sbsi_pkg, sbsi_lane and sbsi_merge.
//
// Each accepted block is registered once; then LANES combinational comparator lanes check
// every valid A element of the held pair against every valid B element, the list state is
// updated and the hit mask moves into the result stage. The result stage sends one item per
// cycle while m_tready is high, so a block yields max(1, number of matches) items, up to
// LANES, and blocks of a single item are accepted in consecutive cycles. An input register
// and the result register let one new block wait while the results of the previous one drain.
`timescale 1ns / 1ps
`default_nettype none

module sorted_block_set_intersection #(
  parameter int LANES = sbsi_pkg::LANES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata fields from bit 0: elem_count (5), elem_0 .. elem_15 (32 each), zero fill.
  input  logic [sbsi_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser fields from bit 0: list_side (1).
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata fields from bit 0: match_value (32), want_next (2), finished (1), zero fill.
  output logic [sbsi_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: match_valid (1).
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import sbsi_pkg::*;

  localparam int CW = $clog2(LANES + 1);
  localparam int IW = $clog2(LANES);

  logic                 in_valid;
  logic                 in_side;
  logic [CW-1:0]        in_cnt;
  logic                 in_fin;
  logic [ELEM_W-1:0]    in_lanes [LANES];

  logic                 held_a;
  logic                 held_b;
  logic                 fin_a;
  logic                 fin_b;
  logic                 done;
  logic [CW-1:0]        cnt_a;
  logic [CW-1:0]        cnt_b;
  logic [ELEM_W-1:0]    blk_a [LANES];
  logic [ELEM_W-1:0]    blk_b [LANES];

  logic [CNT_IN_W-1:0]  raw_cnt;
  logic [CNT_IN_W-1:0]  sat_cnt;
  logic                 can_load;
  logic                 advance;
  logic                 ignore;
  logic                 other_held;
  logic                 hits_en;
  logic [ELEM_W-1:0]    eff_a [LANES];
  logic [ELEM_W-1:0]    eff_b [LANES];
  logic [CW-1:0]        eff_cnt_a;
  logic [CW-1:0]        eff_cnt_b;
  logic                 eff_fin_a;
  logic                 eff_fin_b;
  logic [ELEM_W-1:0]    a_last;
  logic [ELEM_W-1:0]    b_last;
  logic                 drop_a;
  logic                 drop_b;
  logic [LANES-1:0]     a_mask;
  logic [LANES-1:0]     b_mask;
  logic [LANES-1:0]     hits;
  logic                 held_a_next;
  logic                 held_b_next;
  logic                 done_next;
  step_ctl_t            ctl;

  assign raw_cnt = s_tdata[CNT_IN_W-1:0];

  always_comb begin
    if (raw_cnt == '0) begin
      sat_cnt = CNT_IN_W'(1);
    end else if (raw_cnt > CNT_IN_W'(LANES)) begin
      sat_cnt = CNT_IN_W'(LANES);
    end else begin
      sat_cnt = raw_cnt;
    end
  end

  assign s_tready = !in_valid || can_load;
  assign advance  = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_side <= s_tuser;
      in_cnt  <= CW'(sat_cnt);
      in_fin  <= s_tlast;
      for (int i = 0; i < LANES; i++) begin
        in_lanes[i] <= s_tdata[CNT_IN_W + ELEM_W*i +: ELEM_W];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      eff_a[i] = in_side ? blk_a[i] : in_lanes[i];
      eff_b[i] = in_side ? in_lanes[i] : blk_b[i];
    end
    eff_cnt_a = in_side ? cnt_a : in_cnt;
    eff_cnt_b = in_side ? in_cnt : cnt_b;
    eff_fin_a = in_side ? fin_a : in_fin;
    eff_fin_b = in_side ? in_fin : fin_b;
    for (int i = 0; i < LANES; i++) begin
      a_mask[i] = CW'(i) < eff_cnt_a;
      b_mask[i] = CW'(i) < eff_cnt_b;
    end
    a_last = eff_a[IW'(eff_cnt_a - CW'(1))];
    b_last = eff_b[IW'(eff_cnt_b - CW'(1))];
    drop_a = a_last <= b_last;
    drop_b = a_last >= b_last;
  end

  always_comb begin
    ignore      = done || (!in_side && held_a) || (in_side && held_b);
    other_held  = in_side ? held_a : held_b;
    held_a_next = held_a;
    held_b_next = held_b;
    done_next   = done;
    hits_en     = 1'b0;
    ctl.want    = need_code(held_a, held_b, done);
    ctl.fin     = done;
    if (!ignore) begin
      if (!other_held) begin
        held_a_next = held_a || !in_side;
        held_b_next = held_b || in_side;
        ctl.want    = in_side ? WANT_A : WANT_B;
      end else begin
        held_a_next = !drop_a;
        held_b_next = !drop_b;
        done_next   = (drop_a && eff_fin_a) || (drop_b && eff_fin_b);
        hits_en     = 1'b1;
        ctl.want    = need_code(held_a_next, held_b_next, done_next);
        ctl.fin     = done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_a <= 1'b0;
      held_b <= 1'b0;
      fin_a  <= 1'b0;
      fin_b  <= 1'b0;
      done   <= 1'b0;
      cnt_a  <= '0;
      cnt_b  <= '0;
    end else if (advance && !ignore) begin
      held_a <= held_a_next;
      held_b <= held_b_next;
      done   <= done_next;
      if (!in_side) begin
        cnt_a <= in_cnt;
        fin_a <= in_fin;
      end else begin
        cnt_b <= in_cnt;
        fin_b <= in_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !ignore) begin
      if (!in_side) begin
        blk_a <= in_lanes;
      end else begin
        blk_b <= in_lanes;
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sbsi_lane #(
      .LANES (LANES)
    ) u_lane (
      .a_elem  (eff_a[g]),
      .a_ok    (a_mask[g] && hits_en),
      .b_elems (eff_b),
      .b_mask  (b_mask),
      .hit     (hits[g])
    );
  end

  sbsi_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_hits (hits),
    .load_vals (eff_a),
    .load_ctl  (ctl),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  a_never_both_held: assert property (@(posedge clk) disable iff (rst)
    !(held_a && held_b))
    else $error("both blocks still held after a compare");

  a_done_freezes: assert property (@(posedge clk) disable iff (rst)
    done |=> (done && $stable(held_a) && $stable(held_b)))
    else $error("list state changed after the intersection finished");

  a_hits_need_pair: assert property (@(posedge clk) disable iff (rst)
    (advance && (|hits)) |-> (!ignore && other_held))
    else $error("matches reported without a held pair");

endmodule

`default_nettype wire
